// ----- rtl/core/tkst_pkg.sv -----
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int SCORE_W = 16;
    localparam int COUNT_W = 5;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    // Configuration register indexes
    localparam logic CFG_MIN_SCORE  = 1'b0;
    localparam logic CFG_HOLD_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] HOLD_COUNT_RESET = 5'd16;

    // What one cell hands to its right neighbor
    typedef struct packed
    {
        logic               ge;   // cell holds a score at least the candidate
        logic [SCORE_W-1:0] val;  // score held in the cell
    } cell_link_t;

endpackage

// ----- rtl/core/tkst_cell.sv -----
`timescale 1ns / 1ps

module tkst_cell
(
    input  logic                         clk,
    input  logic                         update,
    input  logic                         occupied,
    input  logic [tkst_pkg::SCORE_W-1:0] score,
    input  tkst_pkg::cell_link_t         left,
    output tkst_pkg::cell_link_t         right
);

    logic [tkst_pkg::SCORE_W-1:0] val_reg;
    logic [tkst_pkg::SCORE_W-1:0] val_next;
    logic                         ge;

    assign ge = occupied && (val_reg >= score);

    always_comb
    begin
        val_next = val_reg;
        if (update && !ge)
        begin
            // first cell below the candidate takes it, the rest shift down one
            if (left.ge)
            begin
                val_next = score;
            end
            else
            begin
                val_next = left.val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign right.ge  = ge;
    assign right.val = val_reg;

endmodule

// ----- rtl/core/top_k_score_tracker.sv -----
`timescale 1ns / 1ps

// Top-k score tracker. Holds the highest hold_count scores (at most STORE_DEPTH)
// seen since the last clear, in descending order, in a row of cells; each
// cell compares its score with the candidate and hands its score and compare
// result to its right neighbor, so an insertion shifts the lower part of the
// row down by one in one row update. An insert is kept only if it is at least
// min_score and strictly above the current threshold; a tie ranks below held
// scores. Every input beat gives exactly one result beat (kept, threshold,
// held). An item first updates the row; then, once the result register is
// free, the threshold is read from the updated row into it. A new item can be
// taken while an earlier result still waits on out_stall. Write the
// configuration registers only while the block is idle.
module top_k_score_tracker
#(
    parameter int STORE_DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [tkst_pkg::SCORE_W-1:0] cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [tkst_pkg::SCORE_W-1:0] score,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kept,
    output logic [tkst_pkg::SCORE_W-1:0] threshold,
    output logic [tkst_pkg::COUNT_W-1:0] held
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int WW = (CW > tkst_pkg::COUNT_W) ? CW : tkst_pkg::COUNT_W;

    logic [tkst_pkg::SCORE_W-1:0] min_score_reg;
    logic [tkst_pkg::COUNT_W-1:0] hold_count_reg;
    logic [CW-1:0]                held_count_reg;
    logic [CW-1:0]                held_count_next;
    logic                         pend_reg;
    logic                         pend_kept_reg;
    logic                         out_valid_reg;
    logic                         kept_reg;
    logic [tkst_pkg::SCORE_W-1:0] threshold_reg;
    logic [tkst_pkg::COUNT_W-1:0] held_reg;

    logic [WW-1:0]                hold_w;
    logic [WW-1:0]                held_wide;
    logic [CW-1:0]                keff;
    logic [CW-1:0]                nocc;
    logic                         full;
    logic [tkst_pkg::SCORE_W-1:0] thr_cur;
    logic                         in_beat;
    logic                         is_clear;
    logic                         accept_ins;
    logic                         out_load;

    tkst_pkg::cell_link_t         link [STORE_DEPTH+1];

    assign cfg_ready = 1'b1;
    assign in_stall  = pend_reg;
    assign in_beat   = in_valid && !in_stall;
    assign is_clear  = (op == tkst_pkg::OP_CLEAR);

    // Effective hold count: clamp to 1..STORE_DEPTH
    assign hold_w = WW'(hold_count_reg);
    always_comb
    begin
        if (hold_count_reg == '0)
        begin
            keff = CW'(1);
        end
        else if (hold_w > WW'(STORE_DEPTH))
        begin
            keff = CW'(STORE_DEPTH);
        end
        else
        begin
            keff = CW'(hold_w);
        end
    end

    assign full = (held_count_reg >= keff);
    assign nocc = full ? keff : held_count_reg;

    // link[j] carries the score of cell j-1, so the keff-th score sits on link[keff]
    assign thr_cur = full ? link[keff].val : min_score_reg;

    assign accept_ins = in_beat && !is_clear && (score >= min_score_reg) && (score > thr_cur);

    // Head of the row: the candidate goes into cell 0 unless cell 0 keeps its score
    assign link[0].ge  = 1'b1;
    assign link[0].val = score;

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        tkst_cell u_cell
        (
            .clk      (clk),
            .update   (accept_ins),
            .occupied (CW'(i) < nocc),
            .score    (score),
            .left     (link[i]),
            .right    (link[i+1])
        );
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        if (in_beat && is_clear)
        begin
            held_count_next = '0;
        end
        else if (accept_ins)
        begin
            held_count_next = (nocc < keff) ? nocc + CW'(1) : keff;
        end
    end

    assign out_load  = pend_reg && (!out_valid_reg || !out_stall);
    assign held_wide = WW'(held_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_score_reg  <= '0;
            hold_count_reg <= tkst_pkg::HOLD_COUNT_RESET;
            held_count_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tkst_pkg::CFG_MIN_SCORE:  min_score_reg  <= cfg_data;
                    tkst_pkg::CFG_HOLD_COUNT: hold_count_reg <= cfg_data[tkst_pkg::COUNT_W-1:0];
                    default:                  ;
                endcase
            end
            held_count_reg <= held_count_next;
            // hold the beat until the result register frees up
            if (in_beat)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pend_kept_reg <= accept_ins;
        end
        if (out_load)
        begin
            kept_reg      <= pend_kept_reg;
            threshold_reg <= thr_cur;
            held_reg      <= held_wide[tkst_pkg::COUNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign kept      = kept_reg;
    assign threshold = threshold_reg;
    assign held      = held_reg;

endmodule

// ----- rtl/core/tkst_checker.sv -----
`timescale 1ns / 1ps

module tkst_checker
#(
    parameter int STORE_DEPTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         kept,
    input logic [tkst_pkg::SCORE_W-1:0] threshold,
    input logic [tkst_pkg::COUNT_W-1:0] held
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kept) && $stable(threshold)
                                   && $stable(held))
        else $error("result beat changed while stalled");

    // One item at a time: the cycle after an input beat the input stalls
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is still pending");

    // A kept score leaves at least one held
    a_kept_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kept |-> held != '0)
        else $error("kept reported with empty store");

    // The store never holds more than its depth
    a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(held) <= 32'(STORE_DEPTH))
        else $error("held count above store depth");

endmodule

bind top_k_score_tracker tkst_checker #(.STORE_DEPTH(STORE_DEPTH)) u_tkst_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kept      (kept),
    .threshold (threshold),
    .held      (held)
);
